### rtl/arpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_pkg: shared types and constants for the pseudocolor mapper
// Defines the item payloads, the configuration addresses and the default sizes.
// ----------------------------------------------------------------------------
package arpm_pkg;

    localparam int MAX_PIXELS_DEF  = 4096;
    localparam int MAP_ENTRIES_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CNT_W   = 13;
    localparam int PADDR_W = 5;
    localparam logic [7:0] ALPHA_VALUE = 8'd153;

    localparam logic [2:0] REG_MAP_SELECT = 3'd0;
    localparam logic [2:0] REG_AUTO_RANGE = 3'd1;
    localparam logic [2:0] REG_FIXED_MIN  = 3'd2;
    localparam logic [2:0] REG_FIXED_MAX  = 3'd3;
    localparam logic [2:0] REG_COLUMNS    = 3'd4;
    localparam logic [2:0] REG_ROWS       = 3'd5;
    localparam logic [2:0] REG_ROW_OFFSET = 3'd6;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    typedef struct packed {
        logic                       op;
        logic [SAMPLE_BITS_DEF-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // store sample, update min/max
        logic first;      // first sample of the frame
        logic rd;         // read store at position
        logic norm;       // compute difference, range
        logic mul;        // multiply by map scale
        logic div_start;  // start the divider
        logic emit;       // color lookup, present result
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

### rtl/arpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module arpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/arpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_datapath: sample store, range tracking, index divider and color map
// Executes the controller's commands one step at a time.
// ----------------------------------------------------------------------------
module arpm_datapath import arpm_pkg::*; #(
    parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    input  logic                          i_map_select,
    input  logic                          i_auto_range,
    input  logic signed [15:0]            i_fixed_min,
    input  logic signed [15:0]            i_fixed_max,
    output t_out_item                     o_item
);
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int IW = $clog2(MAP_ENTRIES);
    localparam int DW = SAMPLE_BITS + 1;           // difference / range width
    localparam int PW = DW + IW;                   // product width
    localparam int DCW = $clog2(PW + 1);
    localparam int E  = MAP_ENTRIES / 8;
    localparam logic [IW-1:0] IDX_MAX = IW'(MAP_ENTRIES - 1);

    logic signed [SAMPLE_BITS-1:0] r_min, r_max, rd_data;
    logic signed [SAMPLE_BITS-1:0] lo, hi;
    logic signed [DW-1:0]          r_diff, r_range;
    logic [PW-1:0]                 r_num, r_quo;
    logic [DW:0]                   r_rem;
    logic [DCW-1:0]                r_dcnt;
    logic                          r_busy, r_zero, r_sat;
    t_out_item                     r_item;

    arpm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_PIXELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_addr (i_addr),
        .i_wdata(i_sample),
        .o_rdata(rd_data)
    );

    assign lo = i_auto_range ? r_min : SAMPLE_BITS'(i_fixed_min);
    assign hi = i_auto_range ? r_max : SAMPLE_BITS'(i_fixed_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_cmd.load) begin
            if (i_cmd.first || i_sample < r_min) r_min <= i_sample;
            if (i_cmd.first || i_sample > r_max) r_max <= i_sample;
        end
    end

    // restoring divider: one quotient bit a cycle
    logic [DW:0] rem_sh;
    assign rem_sh = {r_rem[DW-1:0], r_num[PW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.norm) begin
                r_diff  <= DW'(rd_data) - DW'(lo);
                r_range <= DW'(hi) - DW'(lo);
            end
            if (i_cmd.mul) begin
                r_zero <= (r_range <= 0) || (r_diff <= 0);
                r_sat  <= r_diff >= r_range;
                r_num  <= PW'(unsigned'(r_diff)) * PW'(MAP_ENTRIES - 1);
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_dcnt <= DCW'(PW);
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[PW-2:0], 1'b0};
                if (rem_sh >= (DW+1)'(unsigned'(r_range))) begin
                    r_rem <= rem_sh - (DW+1)'(unsigned'(r_range));
                    r_quo <= {r_quo[PW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[PW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == DCW'(1)) r_busy <= 1'b0;
            end
        end
    end
    assign o_sts.div_done = r_busy && (r_dcnt == DCW'(1));

    // color map entries, evaluated once per index at elaboration
    function automatic logic [7:0] ramp_up(input int n);
        int v;
        begin
            v = (255 * 4 * n) / MAP_ENTRIES;
            ramp_up = (n <= 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
    endfunction

    function automatic logic [7:0] ramp_down(input int n);
        int t, v;
        begin
            t = MAP_ENTRIES - 4 * n;
            v = (255 * t) / MAP_ENTRIES;
            ramp_down = (t <= 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
    endfunction

    function automatic logic [23:0] color(input logic sel, input logic [IW-1:0] idx);
        int i, g;
        begin
            i = int'(idx);
            g = (255 * i) / (MAP_ENTRIES - 1);
            if (!sel) color = {3{8'(g)}};
            else if (i < E) color = {16'd0, ramp_up(i + E)};
            else if (i < 3 * E) color = {8'd0, ramp_up(i - E), 8'd255};
            else if (i < 5 * E) color = {ramp_up(i - 3 * E), 8'd255, ramp_down(i - 3 * E)};
            else if (i < 7 * E) color = {8'd255, ramp_down(i - 5 * E), 8'd0};
            else color = {ramp_down(i - 7 * E), 16'd0};
        end
    endfunction

    logic [23:0] lut_grey [MAP_ENTRIES];
    logic [23:0] lut_jet  [MAP_ENTRIES];

    for (genvar k = 0; k < MAP_ENTRIES; k++) begin : g_lut
        assign lut_grey[k] = color(1'b0, IW'(k));
        assign lut_jet[k]  = color(1'b1, IW'(k));
    end

    logic [IW-1:0] idx;
    logic [23:0]   rgb;
    always_comb begin
        priority if (r_zero) idx = '0;
        else if (r_sat) idx = IDX_MAX;
        else idx = r_quo[IW-1:0];
        rgb = i_map_select ? lut_jet[idx] : lut_grey[idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_item <= '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                        alpha: ALPHA_VALUE, last_pixel: i_last};
        end
    end
    assign o_item = r_item;
endmodule

### rtl/arpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_ctrl: frame counters and sequencing state machine
// Tracks load and readout positions and steps the datapath through a pixel.
// ----------------------------------------------------------------------------
module arpm_ctrl import arpm_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_op,
    input  logic [CNT_W-1:0]              i_columns,
    input  logic [CNT_W-1:0]              i_rows,
    input  logic [CNT_W-1:0]              i_row_offset,
    input  t_sts                          i_sts,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_PIXELS)-1:0] o_addr,
    output logic                          o_last,
    output logic                          o_busy,
    output logic                          o_valid
);
    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_NORM, S_MUL, S_DIV, S_EMIT} t_state;
    t_state r_state;

    logic [SW-1:0] r_load_cnt, r_emit_cnt, r_pos;
    logic          r_full, r_last, r_valid;
    logic [25:0]   prod, sprod;
    logic [SW-1:0] size, start;
    logic [CNT_W-1:0] cols, rws;

    assign cols  = (i_columns == '0) ? CNT_W'(1) : i_columns;
    assign rws   = (i_rows == '0) ? CNT_W'(1) : i_rows;
    assign prod  = cols * rws;
    assign size  = (prod > 26'(MAX_PIXELS)) ? SW'(MAX_PIXELS) : prod[SW-1:0];
    assign sprod = i_row_offset * cols;
    assign start = (i_row_offset > i_rows || sprod >= 26'(size)) ? '0 : sprod[SW-1:0];

    logic load_ok, emit_ok, restart;
    assign load_ok = i_start && !o_busy && (i_op == OP_LOAD);
    assign emit_ok = i_start && !o_busy && (i_op == OP_EMIT) && r_full;
    assign restart = r_full || (r_load_cnt >= size);

    logic [SW-1:0] ec;
    assign ec = (r_emit_cnt >= size) ? '0 : r_emit_cnt;

    always_comb begin
        o_cmd = '0;
        o_cmd.load  = load_ok;
        o_cmd.first = restart || (r_load_cnt == '0);
        o_cmd.rd    = (r_state == S_READ);
        o_cmd.norm  = (r_state == S_NORM);
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_MUL);
        o_cmd.emit  = (r_state == S_EMIT);
        o_addr = (r_state == S_IDLE) ? (restart ? '0 : r_load_cnt[AW-1:0]) : r_pos[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_cnt <= '0;
            r_emit_cnt <= '0;
            r_full     <= 1'b0;
            r_valid    <= 1'b0;
            r_last     <= 1'b0;
            r_pos      <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (load_ok) begin
                        r_load_cnt <= (restart ? SW'(0) : r_load_cnt) + 1'b1;
                        if ((restart ? SW'(0) : r_load_cnt) + 1'b1 >= size) begin
                            r_full <= 1'b1;
                        end else begin
                            r_full <= 1'b0;
                        end
                        r_emit_cnt <= '0;
                    end else if (emit_ok) begin
                        // wrap position into the frame
                        r_pos  <= ((start + ec) >= size) ? start + ec - size : start + ec;
                        r_last <= (ec == size - 1'b1);
                        r_emit_cnt <= (ec == size - 1'b1) ? '0 : ec + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_NORM;
                S_NORM: r_state <= S_MUL;
                S_MUL:  r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_last  = r_last;
endmodule

### rtl/auto_range_pseudocolor_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_range_pseudocolor_mapper: frame store with jet/grey pseudocolor readout
// Loads Q8.8 samples, tracks min/max, and emits one RGBA pixel per readout.
// ----------------------------------------------------------------------------
// A load item leaves busy low, so loads go back to back. A readout item holds
// busy through the read, normalize, multiply, divide and emit states; the
// restoring divider forms the map index one bit per cycle. The pixel is strobed
// on o_valid from a register set in the emit state. A new readout is accepted
// only once busy falls; the receiver cannot stall. Reset (synchronous, active
// low) clears counters and min/max and sets configuration registers to defaults.
module auto_range_pseudocolor_mapper import arpm_pkg::*; #(
    parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
    parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_valid,
    output t_out_item          o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // configuration registers
    logic             r_map_select, r_auto_range;
    logic signed [15:0] r_fixed_min, r_fixed_max;
    logic [CNT_W-1:0] r_columns, r_rows, r_row_offset;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_select <= 1'b1;
            r_auto_range <= 1'b1;
            r_fixed_min  <= -16'sd256;
            r_fixed_max  <= 16'sd256;
            r_columns    <= CNT_W'(64);
            r_rows       <= CNT_W'(64);
            r_row_offset <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_MAP_SELECT: r_map_select <= pwdata[0];
                REG_AUTO_RANGE: r_auto_range <= pwdata[0];
                REG_FIXED_MIN:  r_fixed_min  <= pwdata[15:0];
                REG_FIXED_MAX:  r_fixed_max  <= pwdata[15:0];
                REG_COLUMNS:    r_columns    <= pwdata[CNT_W-1:0];
                REG_ROWS:       r_rows       <= pwdata[CNT_W-1:0];
                REG_ROW_OFFSET: r_row_offset <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAP_SELECT: prdata = {31'd0, r_map_select};
            REG_AUTO_RANGE: prdata = {31'd0, r_auto_range};
            REG_FIXED_MIN:  prdata = {{16{r_fixed_min[15]}}, r_fixed_min};
            REG_FIXED_MAX:  prdata = {{16{r_fixed_max[15]}}, r_fixed_max};
            REG_COLUMNS:    prdata = 32'(r_columns);
            REG_ROWS:       prdata = 32'(r_rows);
            REG_ROW_OFFSET: prdata = 32'(r_row_offset);
            default:        prdata = '0;
        endcase
    end

    t_cmd cmd;
    t_sts sts;
    logic [$clog2(MAX_PIXELS)-1:0] addr;
    logic last;

    // controller: counters and pixel sequencing
    arpm_ctrl #(.MAX_PIXELS(MAX_PIXELS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_item.op),
        .i_columns   (r_columns),
        .i_rows      (r_rows),
        .i_row_offset(r_row_offset),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_addr      (addr),
        .o_last      (last),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    // datapath: store, range, divider, color map
    arpm_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAP_ENTRIES(MAP_ENTRIES),
        .SAMPLE_BITS(SAMPLE_BITS_DEF)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_addr      (addr),
        .i_sample    (i_item.sample),
        .i_last      (last),
        .i_map_select(r_map_select),
        .i_auto_range(r_auto_range),
        .i_fixed_min (r_fixed_min),
        .i_fixed_max (r_fixed_max),
        .o_item      (o_item)
    );
endmodule

### rtl/arpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpm_props: port-level checks for the pseudocolor mapper
// Watches the start/busy handshake and the result strobe.
// ----------------------------------------------------------------------------
module arpm_props import arpm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_valid,
    input t_out_item o_item
);
    // a load never makes the block busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == OP_LOAD |=> !busy)
        else $error("load made the block busy");
    // a result always carries alpha 153
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.alpha == ALPHA_VALUE)
        else $error("alpha not 153");
    // a result strobe follows the end of a busy interval
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without work");
    // results are single pulses
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result held");
endmodule

bind auto_range_pseudocolor_mapper arpm_props u_arpm_props (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_item (i_item),
    .o_valid(o_valid),
    .o_item (o_item)
);
